/* design/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the source text tokenizer: token kinds,
// scanner modes, result field widths and the token record.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int LENGTH_BITS_DEF   = 16;
	localparam int POSITION_BITS_DEF = 24;

	// result field widths
	localparam int KIND_W   = 5;
	localparam int START_W  = 24;
	localparam int LENGTH_W = 16;
	localparam int LINE_W   = 16;
	localparam int OUT_DATA_W = 64;

	typedef enum logic [KIND_W-1:0] {
		KIND_WORD        = 5'd0,
		KIND_STRUCT      = 5'd1,
		KIND_NUMBER      = 5'd2,
		KIND_STRING      = 5'd3,
		KIND_COMMA       = 5'd4,
		KIND_PERIOD      = 5'd5,
		KIND_SEMI        = 5'd6,
		KIND_LBRACE      = 5'd7,
		KIND_RBRACE      = 5'd8,
		KIND_LPAREN      = 5'd9,
		KIND_RPAREN      = 5'd10,
		KIND_LBRACK      = 5'd11,
		KIND_RBRACK      = 5'd12,
		KIND_LT          = 5'd13,
		KIND_LE          = 5'd14,
		KIND_GT          = 5'd15,
		KIND_GE          = 5'd16,
		KIND_ASSIGN      = 5'd17,
		KIND_EQ          = 5'd18,
		KIND_PLUS        = 5'd19,
		KIND_PLUS_EQ     = 5'd20,
		KIND_MINUS       = 5'd21,
		KIND_MINUS_EQ    = 5'd22,
		KIND_STAR        = 5'd23,
		KIND_STAR_EQ     = 5'd24,
		KIND_SLASH       = 5'd25,
		KIND_SLASH_EQ    = 5'd26,
		KIND_BAD_CHAR    = 5'd27,
		KIND_STR_NEWLINE = 5'd28,
		KIND_UNCLOSED    = 5'd29
	} kind_t;

	typedef enum logic [4:0] {
		MODE_IDLE       = 5'd0,
		MODE_WORD       = 5'd1,
		MODE_NUM_INT    = 5'd2,
		MODE_NUM_FRAC   = 5'd3,
		MODE_STRING     = 5'd4,
		MODE_LINE_COM   = 5'd5,
		MODE_BLOCK_COM  = 5'd6,
		MODE_BLOCK_STAR = 5'd7,
		MODE_OP_LT      = 5'd13,
		MODE_OP_GT      = 5'd15,
		MODE_OP_ASSIGN  = 5'd17,
		MODE_OP_PLUS    = 5'd19,
		MODE_OP_MINUS   = 5'd21,
		MODE_OP_STAR    = 5'd23,
		MODE_OP_SLASH   = 5'd25
	} mode_t;

	typedef struct packed {
		kind_t               kind;
		logic [START_W-1:0]  start;
		logic [LENGTH_W-1:0] length;
		logic [LINE_W-1:0]   line;
	} token_t;

endpackage

/* design/stt_scan.sv */
// ----------------------------------------------------------------------------
// stt_scan
// Input beat register and scanner state. Each registered byte is scanned
// combinationally: pending token continuation, fresh token start and end-of-text
// flush, giving up to two tokens per byte.
// ----------------------------------------------------------------------------
module stt_scan
	import stt_pkg::*;
#(
	parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       buf_free,
	output logic       push,
	output logic [1:0] push_count,
	output token_t     res0,
	output token_t     res1
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0]   LEN_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [LINE_W-1:0]        LINE_MAX = {LINE_W{1'b1}};
	localparam logic [2:0] KW_DONE = 3'd6;
	localparam logic [2:0] KW_MISS = 3'd7;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// letters of the one keyword
	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = "s";
			3'd1:    c = "t";
			3'd2:    c = "r";
			3'd3:    c = "u";
			3'd4:    c = "c";
			3'd5:    c = "t";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic kind_t op_kind(input mode_t m, input logic with_eq);
		kind_t k;
		unique case (m)
			MODE_OP_LT:     k = with_eq ? KIND_LE       : KIND_LT;
			MODE_OP_GT:     k = with_eq ? KIND_GE       : KIND_GT;
			MODE_OP_ASSIGN: k = with_eq ? KIND_EQ       : KIND_ASSIGN;
			MODE_OP_PLUS:   k = with_eq ? KIND_PLUS_EQ  : KIND_PLUS;
			MODE_OP_MINUS:  k = with_eq ? KIND_MINUS_EQ : KIND_MINUS;
			MODE_OP_STAR:   k = with_eq ? KIND_STAR_EQ  : KIND_STAR;
			MODE_OP_SLASH:  k = with_eq ? KIND_SLASH_EQ : KIND_SLASH;
			default:        k = KIND_BAD_CHAR;
		endcase
		return k;
	endfunction

	// input register
	logic       valid_s1;
	logic [7:0] text_byte_s1;
	logic       end_of_text_s1;

	// scanner state
	mode_t                    mode_q, mode_d;
	logic [POSITION_BITS-1:0] byte_pos_q, byte_pos_d;
	logic [POSITION_BITS-1:0] pend_start_q, pend_start_d;
	logic [LENGTH_BITS-1:0]   pend_len_q, pend_len_d;
	logic [LINE_W-1:0]        line_q, line_d;
	logic [2:0]               kw_prog_q, kw_prog_d;
	logic                     prev_bslash_q, prev_bslash_d;

	logic [LENGTH_BITS-1:0] len_grown;
	logic [LINE_W-1:0]      line_inc;
	logic                   is_letter, is_digit;
	logic                   consumed, do_finish;

	// token events of this byte, in emission order a, b, f
	logic                a_vld, b_vld, f_vld;
	kind_t               a_kind, b_kind, f_kind;
	logic [START_W-1:0]  a_start, f_start;
	logic [LENGTH_W-1:0] a_len, f_len;
	logic [LINE_W-1:0]   f_line;

	token_t tok_a, tok_b, tok_f;

	assign in_ready = !valid_s1 || buf_free;
	assign push     = valid_s1 && buf_free;

	assign len_grown = (pend_len_q != LEN_MAX) ? pend_len_q + LENGTH_BITS'(1) : pend_len_q;
	assign line_inc  = (line_q != LINE_MAX) ? line_q + LINE_W'(1) : line_q;
	assign is_letter = (text_byte_s1 >= "a" && text_byte_s1 <= "z")
		|| (text_byte_s1 >= "A" && text_byte_s1 <= "Z") || text_byte_s1 == "_";
	assign is_digit  = text_byte_s1 >= "0" && text_byte_s1 <= "9";

	// next state
	always_comb begin
		mode_d        = mode_q;
		byte_pos_d    = byte_pos_q;
		pend_start_d  = pend_start_q;
		pend_len_d    = pend_len_q;
		line_d        = line_q;
		kw_prog_d     = kw_prog_q;
		prev_bslash_d = prev_bslash_q;
		consumed      = 1'b0;
		do_finish     = 1'b0;
		a_vld   = 1'b0;
		a_kind  = KIND_WORD;
		a_start = START_W'(pend_start_q);
		a_len   = LENGTH_W'(pend_len_q);
		b_vld   = 1'b0;
		b_kind  = KIND_BAD_CHAR;
		f_vld   = 1'b0;
		f_kind  = KIND_WORD;
		f_start = START_W'(pend_start_q);
		f_len   = LENGTH_W'(pend_len_q);
		f_line  = line_q;

		if (text_byte_s1 != CH_NUL) begin
			// continue the pending token
			unique case (mode_q)
				MODE_IDLE: begin
					consumed = 1'b0;
				end
				MODE_WORD: begin
					if (is_letter) begin
						consumed   = 1'b1;
						pend_len_d = len_grown;
						if (kw_prog_q < KW_DONE && text_byte_s1 == kw_char(kw_prog_q))
							kw_prog_d = kw_prog_q + 3'd1;
						else
							kw_prog_d = KW_MISS;
					end else begin
						a_vld  = 1'b1;
						a_kind = (kw_prog_q == KW_DONE) ? KIND_STRUCT : KIND_WORD;
						mode_d = MODE_IDLE;
					end
				end
				MODE_NUM_INT: begin
					if (is_digit) begin
						consumed   = 1'b1;
						pend_len_d = len_grown;
					end else if (text_byte_s1 == CH_DOT) begin
						consumed   = 1'b1;
						pend_len_d = len_grown;
						mode_d     = MODE_NUM_FRAC;
					end else begin
						a_vld  = 1'b1;
						a_kind = KIND_NUMBER;
						mode_d = MODE_IDLE;
					end
				end
				MODE_NUM_FRAC: begin
					if (is_digit) begin
						consumed   = 1'b1;
						pend_len_d = len_grown;
					end else begin
						a_vld  = 1'b1;
						a_kind = KIND_NUMBER;
						mode_d = MODE_IDLE;
					end
				end
				MODE_STRING: begin
					consumed   = 1'b1;
					pend_len_d = len_grown;
					if (text_byte_s1 == CH_QUOTE && !prev_bslash_q) begin
						a_vld  = 1'b1;
						a_kind = KIND_STRING;
						a_len  = LENGTH_W'(len_grown);
						mode_d = MODE_IDLE;
					end else begin
						if (text_byte_s1 == CH_NL) begin
							a_vld   = 1'b1;
							a_kind  = KIND_STR_NEWLINE;
							a_start = START_W'(byte_pos_q);
							a_len   = LENGTH_W'(1);
							line_d  = line_inc;
						end
						prev_bslash_d = (text_byte_s1 == CH_BSLASH);
					end
				end
				MODE_LINE_COM: begin
					if (text_byte_s1 == CH_NL)
						mode_d = MODE_IDLE;
					else
						consumed = 1'b1;
				end
				MODE_BLOCK_COM, MODE_BLOCK_STAR: begin
					consumed   = 1'b1;
					pend_len_d = len_grown;
					if (text_byte_s1 == CH_NL)
						line_d = line_inc;
					if (mode_q == MODE_BLOCK_STAR && text_byte_s1 == CH_SLASH)
						mode_d = MODE_IDLE;
					else
						mode_d = (text_byte_s1 == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK_COM;
				end
				MODE_OP_LT, MODE_OP_GT, MODE_OP_ASSIGN, MODE_OP_PLUS, MODE_OP_MINUS,
				MODE_OP_STAR, MODE_OP_SLASH: begin
					priority if (text_byte_s1 == CH_EQUAL) begin
						consumed   = 1'b1;
						pend_len_d = len_grown;
						a_vld      = 1'b1;
						a_kind     = op_kind(mode_q, 1'b1);
						a_len      = LENGTH_W'(len_grown);
						mode_d     = MODE_IDLE;
					end else if (mode_q == MODE_OP_MINUS && is_digit) begin
						consumed   = 1'b1;
						pend_len_d = len_grown;
						mode_d     = MODE_NUM_INT;
					end else if (mode_q == MODE_OP_SLASH && text_byte_s1 == CH_SLASH) begin
						consumed = 1'b1;
						mode_d   = MODE_LINE_COM;
					end else if (mode_q == MODE_OP_SLASH && text_byte_s1 == CH_STAR) begin
						consumed   = 1'b1;
						pend_len_d = len_grown;
						mode_d     = MODE_BLOCK_COM;
					end else begin
						a_vld  = 1'b1;
						a_kind = op_kind(mode_q, 1'b0);
						mode_d = MODE_IDLE;
					end
				end
				default: begin
					mode_d = MODE_IDLE;
				end
			endcase

			// byte not taken by a pending token: start something new
			if (!consumed) begin
				unique case (text_byte_s1)
					CH_SPACE: ;
					CH_NL: line_d = line_inc;
					CH_QUOTE: begin
						mode_d        = MODE_STRING;
						pend_start_d  = byte_pos_q;
						pend_len_d    = LENGTH_BITS'(1);
						prev_bslash_d = 1'b0;
					end
					",": begin b_vld = 1'b1; b_kind = KIND_COMMA;  end
					".": begin b_vld = 1'b1; b_kind = KIND_PERIOD; end
					";": begin b_vld = 1'b1; b_kind = KIND_SEMI;   end
					"{": begin b_vld = 1'b1; b_kind = KIND_LBRACE; end
					"}": begin b_vld = 1'b1; b_kind = KIND_RBRACE; end
					"(": begin b_vld = 1'b1; b_kind = KIND_LPAREN; end
					")": begin b_vld = 1'b1; b_kind = KIND_RPAREN; end
					"[": begin b_vld = 1'b1; b_kind = KIND_LBRACK; end
					"]": begin b_vld = 1'b1; b_kind = KIND_RBRACK; end
					"<", ">", "=", "+", "-", "*", "/": begin
						pend_start_d = byte_pos_q;
						pend_len_d   = LENGTH_BITS'(1);
						unique case (text_byte_s1)
							"<":     mode_d = MODE_OP_LT;
							">":     mode_d = MODE_OP_GT;
							"=":     mode_d = MODE_OP_ASSIGN;
							"+":     mode_d = MODE_OP_PLUS;
							"-":     mode_d = MODE_OP_MINUS;
							"*":     mode_d = MODE_OP_STAR;
							default: mode_d = MODE_OP_SLASH;
						endcase
					end
					default: begin
						if (is_letter) begin
							mode_d       = MODE_WORD;
							pend_start_d = byte_pos_q;
							pend_len_d   = LENGTH_BITS'(1);
							kw_prog_d    = (text_byte_s1 == kw_char(3'd0)) ? 3'd1 : KW_MISS;
						end else if (is_digit) begin
							mode_d       = MODE_NUM_INT;
							pend_start_d = byte_pos_q;
							pend_len_d   = LENGTH_BITS'(1);
						end else begin
							b_vld  = 1'b1;
							b_kind = KIND_BAD_CHAR;
						end
					end
				endcase
			end

			byte_pos_d = (byte_pos_q != POS_MAX) ? byte_pos_q + POSITION_BITS'(1) : byte_pos_q;
			do_finish  = end_of_text_s1;
		end else begin
			// nul byte ends the text and is not scanned
			do_finish = 1'b1;
		end

		if (do_finish) begin
			f_start = START_W'(pend_start_d);
			f_len   = LENGTH_W'(pend_len_d);
			f_line  = line_d;
			unique case (mode_d)
				MODE_WORD: begin
					f_vld  = 1'b1;
					f_kind = (kw_prog_d == KW_DONE) ? KIND_STRUCT : KIND_WORD;
				end
				MODE_NUM_INT, MODE_NUM_FRAC: begin
					f_vld  = 1'b1;
					f_kind = KIND_NUMBER;
				end
				MODE_STRING, MODE_BLOCK_COM, MODE_BLOCK_STAR: begin
					f_vld  = 1'b1;
					f_kind = KIND_UNCLOSED;
				end
				MODE_OP_LT, MODE_OP_GT, MODE_OP_ASSIGN, MODE_OP_PLUS, MODE_OP_MINUS,
				MODE_OP_STAR, MODE_OP_SLASH: begin
					f_vld  = 1'b1;
					f_kind = op_kind(mode_d, 1'b0);
				end
				default: ;
			endcase
			mode_d        = MODE_IDLE;
			byte_pos_d    = '0;
			pend_start_d  = '0;
			pend_len_d    = '0;
			line_d        = LINE_W'(1);
			kw_prog_d     = 3'd0;
			prev_bslash_d = 1'b0;
		end
	end

	// tokens of this byte, packed in order
	always_comb begin
		tok_a = '{kind: a_kind, start: a_start, length: a_len, line: line_q};
		tok_b = '{kind: b_kind, start: START_W'(byte_pos_q), length: LENGTH_W'(1), line: line_q};
		tok_f = '{kind: f_kind, start: f_start, length: f_len, line: f_line};
		res0  = a_vld ? tok_a : (b_vld ? tok_b : tok_f);
		res1  = (a_vld && b_vld) ? tok_b : tok_f;
		push_count = 2'(a_vld) + 2'(b_vld) + 2'(f_vld);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			text_byte_s1   <= in_byte;
			end_of_text_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			byte_pos_q    <= '0;
			pend_start_q  <= '0;
			pend_len_q    <= '0;
			line_q        <= LINE_W'(1);
			kw_prog_q     <= 3'd0;
			prev_bslash_q <= 1'b0;
		end else if (push) begin
			mode_q        <= mode_d;
			byte_pos_q    <= byte_pos_d;
			pend_start_q  <= pend_start_d;
			pend_len_q    <= pend_len_d;
			line_q        <= line_d;
			kw_prog_q     <= kw_prog_d;
			prev_bslash_q <= prev_bslash_d;
		end
	end

endmodule

/* design/stt_out_buf.sv */
// ----------------------------------------------------------------------------
// stt_out_buf
// Result register pair. Holds the zero, one or two tokens of one scanned byte
// and hands them out one beat at a time; the last one carries the run end.
// ----------------------------------------------------------------------------
module stt_out_buf
	import stt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [1:0] push_count,
	input  token_t     res0,
	input  token_t     res1,
	output logic       buf_free,
	output logic       out_valid,
	input  logic       out_ready,
	output token_t     out_token,
	output logic       out_last
);

	logic [1:0] remain_q;
	logic       head_q;
	token_t     slot0_q, slot1_q;

	// free once the last held token leaves this cycle
	assign buf_free  = (remain_q == 2'd0) || (remain_q == 2'd1 && out_ready);
	assign out_valid = (remain_q != 2'd0);
	assign out_last  = (remain_q == 2'd1);
	assign out_token = head_q ? slot1_q : slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= 2'd0;
			head_q   <= 1'b0;
		end else if (push) begin
			remain_q <= push_count;
			head_q   <= 1'b0;
		end else if (out_valid && out_ready) begin
			remain_q <= remain_q - 2'd1;
			head_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= res0;
			slot1_q <= res1;
		end
	end

endmodule

/* design/source_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexical scanner: source bytes in, tokens out with kind, start
// offset, length and line.
//
//   channel   dir  beat                          tlast
//   s_axis    in   one source byte               last byte of the text
//   m_axis    out  one token                     last token caused by a byte
//
// A byte is taken every cycle while the input register is empty or the
// result register is free; it is registered, scanned combinationally and
// its tokens land in a two-entry result register, which feeds m_axis.
// A byte giving two tokens holds the output for two beats while the next
// byte waits; bytes giving no token flow at one per cycle, one-token bytes
// while m_axis is ready. Backpressure on m_axis stalls the scan, then s_axis.
// After reset the scanner is idle at offset zero, line one.
// ----------------------------------------------------------------------------
module source_text_tokenizer
	import stt_pkg::*;
#(
	parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] text_byte
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [4:0] token_kind, [28:5] token_start, [44:29] token_length,
	// [60:45] line_number, [63:61] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast
);

	localparam int PAD_W = OUT_DATA_W - (KIND_W + START_W + LENGTH_W + LINE_W);

	logic       buf_free;
	logic       push;
	logic [1:0] push_count;
	token_t     res0, res1, out_token;

	stt_scan #(
		.LENGTH_BITS   (LENGTH_BITS),
		.POSITION_BITS (POSITION_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.buf_free   (buf_free),
		.push       (push),
		.push_count (push_count),
		.res0       (res0),
		.res1       (res1)
	);

	stt_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_count (push_count),
		.res0       (res0),
		.res1       (res1),
		.buf_free   (buf_free),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_token  (out_token),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {{PAD_W{1'b0}}, out_token.line, out_token.length,
		out_token.start, out_token.kind};

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams source text into the tokenizer and checks every token beat against
// a cycle-free scanner model kept in step with the accepted bytes. Three short
// fixed texts come first, then random, mostly well-formed fragments mixed with
// noise, with random gaps and stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top
	import stt_pkg::*;
();

	localparam int START_LSB   = KIND_W;
	localparam int LENGTH_LSB  = START_LSB + START_W;
	localparam int LINE_LSB    = LENGTH_LSB + LENGTH_W;
	localparam int PAD_LSB     = LINE_LSB + LINE_W;
	localparam int RANDOM_BEATS = 1525;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 20;
	localparam logic [2:0] KW_FULL = 3'd6;
	localparam logic [2:0] KW_MISS = 3'd7;
	localparam logic [7:0] NUL     = 8'h00;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} text_beat_t;

	typedef struct {
		kind_t               kind;
		logic [START_W-1:0]  start;
		logic [LENGTH_W-1:0] length;
		logic [LINE_W-1:0]   line;
		logic                last;
	} token_exp_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = 8'h00;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	text_beat_t text_q[$];
	token_exp_t tokens_due[$];
	int         beats_total;
	int         beats_taken = 0;
	int         tokens_seen = 0;
	int         mismatches = 0;
	int         src_wait = 0;
	int         sink_wait = 0;
	int         quiet = 0;

	// scanner model state
	mode_t               scan_st;
	logic [START_W-1:0]  pos_cnt;
	logic [START_W-1:0]  tok_start;
	logic [LENGTH_W-1:0] tok_len;
	logic [LINE_W-1:0]   line_cnt;
	logic [2:0]          kw_prog;
	logic                after_bslash;
	token_exp_t          step_buf [2];
	int                  step_n;
	string               keyword_text = "struct";

	source_text_tokenizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void emit_tok(kind_t k, logic [START_W-1:0] s, logic [LENGTH_W-1:0] l);
		if (step_n < 2) begin
			step_buf[step_n] = '{kind: k, start: s, length: l, line: line_cnt, last: 1'b0};
			step_n++;
		end
	endfunction

	function automatic void emit_held(kind_t k);
		emit_tok(k, tok_start, tok_len);
		scan_st = MODE_IDLE;
	endfunction

	function automatic void open_tok(mode_t m);
		scan_st   = m;
		tok_start = pos_cnt;
		tok_len   = 16'd1;
	endfunction

	function automatic void grow_len();
		if (tok_len != '1)
			tok_len++;
	endfunction

	function automatic void bump_line();
		if (line_cnt != '1)
			line_cnt++;
	endfunction

	function automatic void clear_scan();
		scan_st      = MODE_IDLE;
		pos_cnt      = '0;
		tok_start    = '0;
		tok_len      = '0;
		line_cnt     = 16'd1;
		kw_prog      = 3'd0;
		after_bslash = 1'b0;
	endfunction

	// carries on the held token; 1 when the byte was used up by it
	function automatic bit continue_token(logic [7:0] c);
		mode_t m;
		m = scan_st;
		case (m)
			MODE_IDLE: return 1'b0;
			MODE_WORD: begin
				if (is_letter(c)) begin
					grow_len();
					if (kw_prog < KW_FULL && c == keyword_text[kw_prog])
						kw_prog++;
					else
						kw_prog = KW_MISS;
					return 1'b1;
				end
				emit_held(kw_prog == KW_FULL ? KIND_STRUCT : KIND_WORD);
				return 1'b0;
			end
			MODE_NUM_INT: begin
				if (is_digit(c)) begin
					grow_len();
					return 1'b1;
				end
				if (c == ".") begin
					grow_len();
					scan_st = MODE_NUM_FRAC;
					return 1'b1;
				end
				emit_held(KIND_NUMBER);
				return 1'b0;
			end
			MODE_NUM_FRAC: begin
				if (is_digit(c)) begin
					grow_len();
					return 1'b1;
				end
				emit_held(KIND_NUMBER);
				return 1'b0;
			end
			MODE_STRING: begin
				grow_len();
				if (c == "\"" && !after_bslash) begin
					emit_held(KIND_STRING);
					return 1'b1;
				end
				if (c == "\n") begin
					emit_tok(KIND_STR_NEWLINE, pos_cnt, 16'd1);
					bump_line();
				end
				after_bslash = (c == "\\");
				return 1'b1;
			end
			MODE_LINE_COM: begin
				if (c == "\n") begin
					scan_st = MODE_IDLE;
					return 1'b0;
				end
				return 1'b1;
			end
			MODE_BLOCK_COM, MODE_BLOCK_STAR: begin
				grow_len();
				if (c == "\n")
					bump_line();
				if (m == MODE_BLOCK_STAR && c == "/")
					scan_st = MODE_IDLE;
				else
					scan_st = (c == "*") ? MODE_BLOCK_STAR : MODE_BLOCK_COM;
				return 1'b1;
			end
			default: begin
				// held operator: its mode value is the single-byte kind
				if (c == "=") begin
					grow_len();
					emit_held(kind_t'(int'(m) + 1));
					return 1'b1;
				end
				if (m == MODE_OP_MINUS && is_digit(c)) begin
					grow_len();
					scan_st = MODE_NUM_INT;
					return 1'b1;
				end
				if (m == MODE_OP_SLASH && c == "/") begin
					scan_st = MODE_LINE_COM;
					return 1'b1;
				end
				if (m == MODE_OP_SLASH && c == "*") begin
					grow_len();
					scan_st = MODE_BLOCK_COM;
					return 1'b1;
				end
				emit_held(kind_t'(int'(m)));
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void close_text();
		case (scan_st)
			MODE_IDLE, MODE_LINE_COM: ;
			MODE_WORD: emit_held(kw_prog == KW_FULL ? KIND_STRUCT : KIND_WORD);
			MODE_NUM_INT, MODE_NUM_FRAC: emit_held(KIND_NUMBER);
			MODE_STRING, MODE_BLOCK_COM, MODE_BLOCK_STAR: emit_held(KIND_UNCLOSED);
			default: emit_held(kind_t'(int'(scan_st)));
		endcase
		clear_scan();
	endfunction

	// scans one accepted byte and queues the tokens it gives
	function automatic void lex_byte(logic [7:0] c, logic fin);
		token_exp_t tok;
		step_n = 0;
		if (c == NUL) begin
			close_text();
		end else begin
			if (!continue_token(c)) begin
				case (c)
					" ": ;
					"\n": bump_line();
					"\"": begin
						open_tok(MODE_STRING);
						after_bslash = 1'b0;
					end
					",": emit_tok(KIND_COMMA, pos_cnt, 16'd1);
					".": emit_tok(KIND_PERIOD, pos_cnt, 16'd1);
					";": emit_tok(KIND_SEMI, pos_cnt, 16'd1);
					"{": emit_tok(KIND_LBRACE, pos_cnt, 16'd1);
					"}": emit_tok(KIND_RBRACE, pos_cnt, 16'd1);
					"(": emit_tok(KIND_LPAREN, pos_cnt, 16'd1);
					")": emit_tok(KIND_RPAREN, pos_cnt, 16'd1);
					"[": emit_tok(KIND_LBRACK, pos_cnt, 16'd1);
					"]": emit_tok(KIND_RBRACK, pos_cnt, 16'd1);
					"<": open_tok(MODE_OP_LT);
					">": open_tok(MODE_OP_GT);
					"=": open_tok(MODE_OP_ASSIGN);
					"+": open_tok(MODE_OP_PLUS);
					"-": open_tok(MODE_OP_MINUS);
					"*": open_tok(MODE_OP_STAR);
					"/": open_tok(MODE_OP_SLASH);
					default: begin
						if (is_letter(c)) begin
							open_tok(MODE_WORD);
							kw_prog = (c == keyword_text[0]) ? 3'd1 : KW_MISS;
						end else if (is_digit(c)) begin
							open_tok(MODE_NUM_INT);
						end else begin
							emit_tok(KIND_BAD_CHAR, pos_cnt, 16'd1);
						end
					end
				endcase
			end
			if (pos_cnt != '1)
				pos_cnt++;
			if (fin)
				close_text();
		end
		for (int i = 0; i < step_n; i++) begin
			tok = step_buf[i];
			tok.last = (i == step_n - 1);
			tokens_due.push_back(tok);
		end
	endfunction

	function automatic int draw_gap(int n);
		// every third stretch of a hundred beats runs with no idling
		return ((n / 100) % 3 == 0) ? 0 : int'($urandom_range(0, 9));
	endfunction

	task automatic report_bad(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: token %0d %s mismatch: got 0x%0h, expected 0x%0h",
			$realtime, tokens_seen, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------
	task automatic push_beat(logic [7:0] c, logic fin);
		text_q.push_back('{ch: c, fin: fin});
	endtask

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++)
			push_beat(s[i], 1'b0);
	endtask

	function automatic logic [7:0] pick_from(string pool);
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	function automatic logic [7:0] pick_letter();
		return pick_from("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_s");
	endfunction

	// closes the text either by a last flag on its final byte or by a zero byte
	task automatic end_text();
		text_beat_t tail;
		if ($urandom_range(0, 1) == 0 && text_q.size() != 0) begin
			tail = text_q.pop_back();
			tail.fin = 1'b1;
			text_q.push_back(tail);
		end else begin
			push_beat(NUL, 1'b0);
		end
	endtask

	task automatic add_fragment();
		int n;
		case ($urandom_range(0, 19))
			0, 1, 2, 3: begin
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 3))
						0: push_str("struct");
						1: push_str("struc");
						2: push_str("structs");
						default: push_str("Struct");
					endcase
				end else begin
					n = $urandom_range(1, 8);
					repeat (n) push_beat(pick_letter(), 1'b0);
				end
			end
			4, 5, 6: begin
				if ($urandom_range(0, 2) == 0)
					push_str("-");
				n = $urandom_range(1, 4);
				repeat (n) push_beat(pick_from("0123456789"), 1'b0);
				if ($urandom_range(0, 1) == 0) begin
					push_str(".");
					n = $urandom_range(0, 3);
					repeat (n) push_beat(pick_from("0123456789"), 1'b0);
				end
			end
			7, 8: begin
				push_str("\"");
				n = $urandom_range(0, 8);
				repeat (n) begin
					case ($urandom_range(0, 7))
						0: push_str("\n");
						1: begin
							push_str("\\");
							push_beat(pick_from("\"\\n"), 1'b0);
						end
						2: push_beat(8'($urandom_range(1, 255)), 1'b0);
						3: push_str(" ");
						default: push_beat(pick_letter(), 1'b0);
					endcase
				end
				if ($urandom_range(0, 7) == 0)
					end_text();
				else
					push_str("\"");
			end
			9, 10, 11: push_beat(pick_from(",.;{}()[]"), 1'b0);
			12, 13, 14: begin
				push_beat(pick_from("<>=+-*/"), 1'b0);
				if ($urandom_range(0, 1) == 0)
					push_str("=");
			end
			15: begin
				push_str("//");
				n = $urandom_range(0, 6);
				repeat (n) push_beat(pick_from("ab */\"x"), 1'b0);
				if ($urandom_range(0, 7) == 0)
					end_text();
				else
					push_str("\n");
			end
			16: begin
				push_str("/*");
				n = $urandom_range(0, 6);
				repeat (n) push_beat(pick_from("ab*/\n *"), 1'b0);
				if ($urandom_range(0, 7) == 0)
					end_text();
				else
					push_str("*/");
			end
			17, 18: push_beat(pick_from(" \n"), 1'b0);
			default: push_beat(8'($urandom_range(1, 255)), 1'b0);
		endcase
		if ($urandom_range(0, 1) == 0)
			push_str(" ");
		if ($urandom_range(0, 39) == 0)
			end_text();
	endtask

	initial begin
		int target;
		clear_scan();
		// keyword, signed fraction, compare-equal, block comment over a line
		// break, high unknown byte closing the text
		push_str("struct -9.1>=/*\n*/");
		push_beat(8'hFF, 1'b1);
		// word and punctuation from one last byte
		push_str("ab");
		push_beat(",", 1'b1);
		// escaped quote, line break inside a string, string left open
		push_str("\"\\\"\n");
		push_beat(NUL, 1'b0);
		target = text_q.size() + RANDOM_BEATS;
		while (text_q.size() < target)
			add_fragment();
		push_beat(NUL, 1'b0);
		beats_total = text_q.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (beats_taken != beats_total)
			@(posedge clk);
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// byte driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		text_beat_t nb;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				lex_byte(s_axis_tdata, s_axis_tlast);
				beats_taken++;
				src_wait = draw_gap(beats_taken);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_wait > 0) begin
					src_wait--;
					s_axis_tvalid <= 1'b0;
				end else if (text_q.size() != 0) begin
					nb = text_q.pop_front();
					s_axis_tdata  <= nb.ch;
					s_axis_tlast  <= nb.fin;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// token monitor
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		token_exp_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				tokens_seen++;
				if (tokens_due.size() == 0) begin
					report_bad("unexpected beat", m_axis_tdata, '0);
				end else begin
					want = tokens_due.pop_front();
					if (m_axis_tdata[KIND_W-1:0] != want.kind)
						report_bad("kind", m_axis_tdata[KIND_W-1:0], want.kind);
					if (m_axis_tdata[START_LSB +: START_W] != want.start)
						report_bad("start", m_axis_tdata[START_LSB +: START_W], want.start);
					if (m_axis_tdata[LENGTH_LSB +: LENGTH_W] != want.length)
						report_bad("length", m_axis_tdata[LENGTH_LSB +: LENGTH_W], want.length);
					if (m_axis_tdata[LINE_LSB +: LINE_W] != want.line)
						report_bad("line", m_axis_tdata[LINE_LSB +: LINE_W], want.line);
					if (m_axis_tdata[OUT_DATA_W-1:PAD_LSB] != '0)
						report_bad("pad", m_axis_tdata[OUT_DATA_W-1:PAD_LSB], '0);
					if (m_axis_tlast != want.last)
						report_bad("tlast", m_axis_tlast, want.last);
				end
				// one long hold-off lets the byte side back up
				sink_wait = (tokens_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap(tokens_seen);
			end
			if (sink_wait > 0) begin
				sink_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// no beat on either side for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule
